/* rtl/core/hxd_pkg.sv */
package hxd_pkg;

  // Field widths fixed by the interface
  localparam int MU_W          = 50;
  localparam int R_W           = 32;
  localparam int OUT_W         = 32;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic [MU_W-1:0] GRAV_RESET = 50'd398600441800000;

  typedef struct packed {
    logic [R_W-1:0] radius_start;
    logic [R_W-1:0] radius_end;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] delta_v_total;
    logic             saturated;
  } out_t;

endpackage

/* rtl/core/hohmann_transfer_delta_v.sv */
// Hohmann transfer delta-v unit.
// Input: pulse start with in_data (radius_start, radius_end in meters); the
// transfer happens at any edge with start high. busy is always low: a new
// radius pair may enter every cycle.
// Output: out_valid is high for one cycle with out_data (delta_v_total in
// unsigned fixed point with FRAC_BITS fraction bits, saturated flag). The
// receiver cannot stall; every result must be taken in its cycle.
// Configuration: cfg_we writes cfg_wdata into the gravitational parameter;
// write it only while no item is in flight.
// Results pass the operand, partial-product and numerator stages, the
// per-bit divider and square root stages, the difference register and the
// output register. Throughput one item per cycle.
// Reset clears the valid bits and loads the default gravitational parameter.
// A zero radius or an overflowing sum returns all ones with saturated set.
module hohmann_transfer_delta_v #(
  parameter int FRAC_BITS = hxd_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  hxd_pkg::in_t               in_data,
  output logic                       out_valid,
  output hxd_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic [hxd_pkg::MU_W-1:0]   cfg_wdata
);
  import hxd_pkg::*;

  localparam int NUM_W   = MU_W + R_W + 2 * FRAC_BITS + 1;
  localparam int DEN_W   = 2 * R_W + 1;
  localparam int ROOT_W  = (NUM_W + 1) / 2;
  localparam int SPD_LAT = NUM_W + ROOT_W;
  localparam int LAT     = SPD_LAT + 5;
  localparam int MU_LO   = MU_W / 2;
  localparam int MU_HI   = MU_W - MU_LO;
  localparam int PX_W    = MU_W + R_W;
  localparam int PH_W    = MU_HI + R_W;
  localparam int PL_W    = MU_LO + R_W;

  logic [MU_W-1:0] grav_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= GRAV_RESET;
    end else if (cfg_we) begin
      grav_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // Stage 0: capture operands
  logic            v0_r, z0_r;
  logic [R_W-1:0]  r1_r, r2_r;
  logic [R_W:0]    rs_r;
  logic [MU_W-1:0] mu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    z0_r <= (in_data.radius_start == '0) || (in_data.radius_end == '0);
    r1_r <= in_data.radius_start;
    r2_r <= in_data.radius_end;
    rs_r <= {1'b0, in_data.radius_start} + {1'b0, in_data.radius_end};
    mu_r <= grav_r;
  end

  // Stage 1: partial products
  logic                  v1_r, z1_r;
  logic [MU_HI+R_W-1:0]  p1h_r, p2h_r;
  logic [MU_LO+R_W-1:0]  p1l_r, p2l_r;
  logic [DEN_W-1:0]      d1_r, d2_r;
  logic [MU_W-1:0]       mu1_r;
  logic [R_W-1:0]        r1b_r, r2b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    z1_r  <= z0_r;
    p1h_r <= PH_W'(mu_r[MU_W-1 -: MU_HI]) * PH_W'(r2_r);
    p1l_r <= PL_W'(mu_r[MU_LO-1:0]) * PL_W'(r2_r);
    p2h_r <= PH_W'(mu_r[MU_W-1 -: MU_HI]) * PH_W'(r1_r);
    p2l_r <= PL_W'(mu_r[MU_LO-1:0]) * PL_W'(r1_r);
    d1_r  <= DEN_W'(r1_r) * DEN_W'(rs_r);
    d2_r  <= DEN_W'(r2_r) * DEN_W'(rs_r);
    mu1_r <= mu_r;
    r1b_r <= r1_r;
    r2b_r <= r2_r;
  end

  // Stage 2: numerators and denominators
  logic             v2_r, z2_r;
  logic [NUM_W-1:0] nc_r, nx1_r, nx2_r;
  logic [DEN_W-1:0] dc1_r, dc2_r, dx1_r, dx2_r;
  logic [PX_W-1:0]  px1_nxt, px2_nxt;

  assign px1_nxt = {p1h_r, {MU_LO{1'b0}}} + PX_W'(p1l_r);
  assign px2_nxt = {p2h_r, {MU_LO{1'b0}}} + PX_W'(p2l_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    z2_r  <= z1_r;
    nc_r  <= NUM_W'({mu1_r, {(2 * FRAC_BITS){1'b0}}});
    nx1_r <= {px1_nxt, {(2 * FRAC_BITS + 1){1'b0}}};
    nx2_r <= {px2_nxt, {(2 * FRAC_BITS + 1){1'b0}}};
    dc1_r <= DEN_W'(r1b_r);
    dc2_r <= DEN_W'(r2b_r);
    dx1_r <= d1_r;
    dx2_r <= d2_r;
  end

  // Four speed pipelines
  logic [ROOT_W-1:0] v1c, v2c, v1t, v2t;

  hxd_speed #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_v1c (
    .clk(clk), .num(nc_r),  .den(dc1_r), .root(v1c)
  );
  hxd_speed #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_v2c (
    .clk(clk), .num(nc_r),  .den(dc2_r), .root(v2c)
  );
  hxd_speed #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_v1t (
    .clk(clk), .num(nx1_r), .den(dx1_r), .root(v1t)
  );
  hxd_speed #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_v2t (
    .clk(clk), .num(nx2_r), .den(dx2_r), .root(v2t)
  );

  // Valid and zero-radius bits alongside the speed pipelines
  logic vz_v_r [SPD_LAT];
  logic vz_z_r [SPD_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SPD_LAT; i++) begin
        vz_v_r[i] <= 1'b0;
      end
    end else begin
      vz_v_r[0] <= v2_r;
      for (int i = 1; i < SPD_LAT; i++) begin
        vz_v_r[i] <= vz_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    vz_z_r[0] <= z2_r;
    for (int i = 1; i < SPD_LAT; i++) begin
      vz_z_r[i] <= vz_z_r[i-1];
    end
  end

  // Absolute differences
  logic              vd_r, zd_r;
  logic [ROOT_W-1:0] a1_r, a2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= vz_v_r[SPD_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    zd_r <= vz_z_r[SPD_LAT-1];
    a1_r <= (v1t >= v1c) ? v1t - v1c : v1c - v1t;
    a2_r <= (v2c >= v2t) ? v2c - v2t : v2t - v2c;
  end

  // Sum and saturate
  logic [ROOT_W:0] total_nxt;
  logic            sat_nxt;
  logic            out_valid_r;
  out_t            out_data_r;

  assign total_nxt = {1'b0, a1_r} + {1'b0, a2_r};
  assign sat_nxt   = zd_r ||
                     (total_nxt > {{(ROOT_W + 1 - OUT_W){1'b0}}, {OUT_W{1'b1}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.saturated     <= sat_nxt;
    out_data_r.delta_v_total <= sat_nxt ? {OUT_W{1'b1}} : total_nxt[OUT_W-1:0];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/hxd_speed.sv */
// One speed: floor(sqrt(floor(num / den))).
// Restoring divider at one quotient bit per stage, then a digit-by-digit
// square root at one root bit per stage.
module hxd_speed #(
  parameter int NUM_W = 99,
  parameter int DEN_W = 65
) (
  input  logic                     clk,
  input  logic [NUM_W-1:0]         num,
  input  logic [DEN_W-1:0]         den,
  output logic [(NUM_W+1)/2-1:0]   root
);
  localparam int ROOT_W = (NUM_W + 1) / 2;
  localparam int SQ_W   = 2 * ROOT_W;
  localparam int RW     = ROOT_W + 2;

  // Divider stage registers
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] nq_r  [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];

  // Square root stage registers
  logic [SQ_W-1:0]   op_r [ROOT_W];
  logic [ROOT_W-1:0] rt_r [ROOT_W];
  logic [RW-1:0]     sr_r [ROOT_W];

  genvar g;
  generate
    for (g = 0; g < NUM_W; g++) begin : g_div
      logic [DEN_W-1:0] rem_in;
      logic [DEN_W-1:0] den_in;
      logic [NUM_W-1:0] nq_in;
      logic [DEN_W:0]   t;
      logic             ge;
      if (g == 0) begin : g_first
        assign rem_in = '0;
        assign den_in = den;
        assign nq_in  = num;
      end else begin : g_next
        assign rem_in = rem_r[g-1];
        assign den_in = den_r[g-1];
        assign nq_in  = nq_r[g-1];
      end
      // shift in next numerator bit, trial subtract
      assign t  = {rem_in, nq_in[NUM_W-1]};
      assign ge = (t >= {1'b0, den_in});
      always_ff @(posedge clk) begin
        nq_r[g]  <= {nq_in[NUM_W-2:0], ge};
        rem_r[g] <= ge ? DEN_W'(t - {1'b0, den_in}) : t[DEN_W-1:0];
        den_r[g] <= den_in;
      end
    end

    for (g = 0; g < ROOT_W; g++) begin : g_sqrt
      logic [SQ_W-1:0]   op_in;
      logic [ROOT_W-1:0] rt_in;
      logic [RW-1:0]     sr_in;
      logic [RW+1:0]     t;
      logic [RW+1:0]     trial;
      logic              ge;
      if (g == 0) begin : g_first
        assign op_in = SQ_W'(nq_r[NUM_W-1]);
        assign rt_in = '0;
        assign sr_in = '0;
      end else begin : g_next
        assign op_in = op_r[g-1];
        assign rt_in = rt_r[g-1];
        assign sr_in = sr_r[g-1];
      end
      // bring down two operand bits, try (4*root + 1)
      assign t     = {sr_in, op_in[SQ_W-1 -: 2]};
      assign trial = {2'b00, rt_in, 2'b01};
      assign ge    = (t >= trial);
      always_ff @(posedge clk) begin
        op_r[g] <= {op_in[SQ_W-3:0], 2'b00};
        rt_r[g] <= {rt_in[ROOT_W-2:0], ge};
        sr_r[g] <= ge ? RW'(t - trial) : RW'(t);
      end
    end
  endgenerate

  assign root = rt_r[ROOT_W-1];

endmodule

/* rtl/core/hxd_chk.sv */
module hxd_chk #(
  parameter int LAT = 154
) (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input hxd_pkg::in_t  in_data,
  input logic          out_valid,
  input hxd_pkg::out_t out_data
);
  import hxd_pkg::*;

  // Never holds off the sender
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy) else $error("busy raised");

  // Every result comes from a transfer a fixed latency earlier
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT)) else $error("result without input");

  // Every transfer yields a result after the fixed latency
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid) else $error("result lost");

  // Zero radius saturates
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && (in_data.radius_start == '0 || in_data.radius_end == '0))
    |-> ##LAT (out_data.saturated && (out_data.delta_v_total == {OUT_W{1'b1}})))
    else $error("zero radius not saturated");

endmodule

bind hohmann_transfer_delta_v hxd_chk #(.LAT(LAT)) u_hxd_chk (.*);
